@@ rtl/core/mrope_cos_sin_generator_defines.svh @@
// Assertion macros for the cos/sin generator RTL.
`ifndef MROPE_COS_SIN_GENERATOR_DEFINES_SVH
`define MROPE_COS_SIN_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MROPE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define MROPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MROPE_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define MROPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/core/mrope_pkg.sv @@
package mrope_pkg;

    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [60:0] Q30_HALF      = 61'h2000_0000;
    localparam logic [29:0] EIGHTH_TURN   = 30'h2000_0000;
    localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

    // configuration register indexes
    localparam logic REG_HEIGHT_SECTION = 1'b0;
    localparam logic REG_WIDTH_SECTION  = 1'b1;
    localparam logic [5:0] HEIGHT_SECTION_RST = 6'd20;
    localparam logic [5:0] WIDTH_SECTION_RST  = 6'd20;

    // quadrant of the phase
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    // Horner steps: one cell each, sine and cosine side by side
    localparam int NUM_CELLS = 4;
    localparam int unsigned SIN_DIVS [NUM_CELLS] = '{72, 42, 20, 6};
    localparam int unsigned COS_DIVS [NUM_CELLS] = '{56, 30, 12, 2};

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [1:0]  quad;
        logic        swap;
        logic [5:0]  idx;
        logic        last;
    } lane_t;

    // Elaboration-time helpers for the inverse-frequency table.
    function automatic logic [63:0] mul_q30_c(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bt;
        rem = x;
        res = 64'd0;
        bt  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // log2 of theta in Q32 by repeated squaring of a Q30 mantissa
    function automatic logic [63:0] log2_q32(logic [63:0] theta_in);
        logic [63:0] th;
        logic [63:0] m;
        logic [63:0] frac;
        int n;
        th = (theta_in == 64'd0) ? 64'd1 : theta_in;
        n = 0;
        for (int k = 0; k < 63; k++) begin
            if ((th >> (k + 1)) != 64'd0) n = k + 1;
        end
        m = (n >= 30) ? (th >> (n - 30)) : (th << (30 - n));
        frac = 64'd0;
        for (int j = 0; j < 32; j++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    // 2^-expo / (2 pi) as a 32-bit fraction of a turn
    function automatic logic [31:0] inv_turn(logic [63:0] expo);
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] v;
        logic [63:0] rt;
        logic [63:0] prod;
        int s;
        k  = expo >> 32;
        f  = expo & 64'hFFFF_FFFF;
        v  = 64'd1 << 30;
        rt = isqrt64(64'd1 << 59);
        for (int j = 1; j <= 30; j++) begin
            if (j > 1) rt = isqrt64(rt << 30);
            if (f[32 - j]) v = mul_q30_c(v, rt);
        end
        if (k >= 64'd32) return 32'd0;
        s = 30 + int'(k);
        prod = v * INV_TWO_PI_Q32;
        return 32'((prod + (64'd1 << (s - 1))) >> s);
    endfunction

endpackage

@@ rtl/core/mrope_front.sv @@
module mrope_front #(
    parameter int HEAD_SIZE  = 128,
    parameter int THETA_BASE = 5000000,
    parameter int POS_BITS   = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [19:0]         pos_temporal,
    input  logic [19:0]         pos_height,
    input  logic [19:0]         pos_width,
    input  logic [5:0]          height_section,
    input  logic [5:0]          width_section,
    output logic                lane_valid,
    output mrope_pkg::lane_t    lane
);

    localparam int HalfSlots = HEAD_SIZE / 2;
    localparam int EmitSlots = (HalfSlots > 64) ? 64 : HalfSlots;
    localparam int SlotW     = $clog2(EmitSlots);
    localparam int PosW      = (POS_BITS < 20) ? POS_BITS : 20;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(EmitSlots - 1);
    localparam logic [63:0] Log2Theta = mrope_pkg::log2_q32(64'(THETA_BASE));

    // inverse-frequency table, one entry per slot
    logic [31:0] inv_tab [EmitSlots];
    for (genvar gi = 0; gi < EmitSlots; gi++) begin : g_tab
        localparam logic [63:0] Expo = Log2Theta * 64'(2 * gi) / 64'(HEAD_SIZE);
        assign inv_tab[gi] = mrope_pkg::inv_turn(Expo);
    end

    // slot sequencer
    logic             busy_reg;
    logic [SlotW-1:0] slot_reg;
    logic [1:0]       mod3_reg;
    logic [PosW-1:0]  held_reg [3];
    logic             last_issue;
    logic             accept;
    logic [7:0]       lim_h;
    logic [7:0]       lim_w;
    logic [7:0]       slot_ext;
    logic [PosW-1:0]  pos_sel;
    logic [1:0]       mod3_next;

    assign last_issue = busy_reg && en && (slot_reg == LastSlot);
    assign in_ready   = !busy_reg || last_issue;
    assign accept     = in_valid && in_ready;
    assign lim_h      = {2'b00, height_section} + {1'b0, height_section, 1'b0};
    assign lim_w      = {2'b00, width_section} + {1'b0, width_section, 1'b0};
    assign slot_ext   = 8'(slot_reg);
    assign mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;

    always_comb begin
        if (mod3_reg == 2'd1 && slot_ext < lim_h) begin
            pos_sel = held_reg[1];
        end else if (mod3_reg == 2'd2 && slot_ext < lim_w) begin
            pos_sel = held_reg[2];
        end else begin
            pos_sel = held_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
            mod3_reg <= 2'd0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
            mod3_reg <= 2'd0;
        end else if (busy_reg && en) begin
            slot_reg <= slot_reg + 1'b1;
            mod3_reg <= mod3_next;
            if (last_issue) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg[0] <= pos_temporal[PosW-1:0];
            held_reg[1] <= pos_height[PosW-1:0];
            held_reg[2] <= pos_width[PosW-1:0];
        end
    end

    // stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= busy_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // payload: position pick, phase, fold, angle, angle squared
    logic [PosW-1:0]   s1_pos_reg;
    logic [31:0]       s1_inv_reg;
    logic [5:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic              s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg, s5_last_reg;
    logic [31:0]       s2_phase_reg;
    logic [1:0]        s3_quad_reg, s4_quad_reg, s5_quad_reg;
    logic              s3_swap_reg, s4_swap_reg, s5_swap_reg;
    logic [29:0]       s3_r_reg;
    logic [29:0]       s4_x_reg, s5_x_reg;
    logic [29:0]       s5_x2_reg;

    logic [PosW+31:0]  phase_prod;
    logic [29:0]       r_raw;
    logic              swap_now;
    logic [29:0]       r_fold;
    logic [60:0]       x_prod;
    logic [59:0]       x2_prod;

    assign phase_prod = (PosW + 32)'(s1_pos_reg) * (PosW + 32)'(s1_inv_reg);
    assign r_raw      = s2_phase_reg[29:0];
    // fold into the first eighth turn, swapping sine and cosine
    assign swap_now   = r_raw > mrope_pkg::EIGHTH_TURN;
    assign r_fold     = swap_now ? 30'(mrope_pkg::Q30_ONE - {1'b0, r_raw}) : r_raw;
    assign x_prod     = 61'(s3_r_reg) * 61'(mrope_pkg::HALF_PI_Q30);
    assign x2_prod    = 60'(s4_x_reg) * 60'(s4_x_reg) + 60'(mrope_pkg::Q30_HALF);

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pos_reg   <= pos_sel;
            s1_inv_reg   <= inv_tab[slot_reg];
            s1_idx_reg   <= 6'(slot_reg);
            s1_last_reg  <= (slot_reg == LastSlot);

            s2_phase_reg <= phase_prod[31:0];
            s2_idx_reg   <= s1_idx_reg;
            s2_last_reg  <= s1_last_reg;

            s3_quad_reg  <= s2_phase_reg[31:30];
            s3_swap_reg  <= swap_now;
            s3_r_reg     <= r_fold;
            s3_idx_reg   <= s2_idx_reg;
            s3_last_reg  <= s2_last_reg;

            s4_x_reg     <= 30'(x_prod >> 30);
            s4_quad_reg  <= s3_quad_reg;
            s4_swap_reg  <= s3_swap_reg;
            s4_idx_reg   <= s3_idx_reg;
            s4_last_reg  <= s3_last_reg;

            s5_x2_reg    <= 30'(x2_prod >> 30);
            s5_x_reg     <= s4_x_reg;
            s5_quad_reg  <= s4_quad_reg;
            s5_swap_reg  <= s4_swap_reg;
            s5_idx_reg   <= s4_idx_reg;
            s5_last_reg  <= s4_last_reg;
        end
    end

    assign lane_valid = s5_valid_reg;
    always_comb begin
        lane.x    = s5_x_reg;
        lane.x2   = s5_x2_reg;
        lane.ts   = mrope_pkg::Q30_ONE;
        lane.tc   = mrope_pkg::Q30_ONE;
        lane.quad = s5_quad_reg;
        lane.swap = s5_swap_reg;
        lane.idx  = s5_idx_reg;
        lane.last = s5_last_reg;
    end

endmodule

@@ rtl/core/mrope_cell.sv @@
// One Horner step for sine and cosine: t <= 1 - (x2 / D) * t, Q30.
module mrope_cell #(
    parameter int unsigned DIV_SIN = 72,
    parameter int unsigned DIV_COS = 56
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  mrope_pkg::lane_t in_lane,
    output logic             out_valid,
    output mrope_pkg::lane_t out_lane
);

    // exact floor division of a 30-bit value by reciprocal multiply
    localparam int ShiftS = 30 + $clog2(DIV_SIN);
    localparam int ShiftC = 30 + $clog2(DIV_COS);
    localparam logic [63:0] RecipS =
        ((64'd1 << ShiftS) + 64'(DIV_SIN) - 64'd1) / 64'(DIV_SIN);
    localparam logic [63:0] RecipC =
        ((64'd1 << ShiftC) + 64'(DIV_COS) - 64'd1) / 64'(DIV_COS);

    logic [61:0] quo_prod_s;
    logic [61:0] quo_prod_c;
    assign quo_prod_s = 62'(in_lane.x2) * 62'(RecipS[31:0]);
    assign quo_prod_c = 62'(in_lane.x2) * 62'(RecipC[31:0]);

    logic             a_valid_reg;
    mrope_pkg::lane_t a_lane_reg;
    logic [29:0]      a_qs_reg;
    logic [29:0]      a_qc_reg;
    logic             b_valid_reg;
    mrope_pkg::lane_t b_lane_reg;

    logic [60:0]      step_s;
    logic [60:0]      step_c;
    mrope_pkg::lane_t b_lane_next;

    assign step_s = 61'(a_qs_reg) * 61'(a_lane_reg.ts) + mrope_pkg::Q30_HALF;
    assign step_c = 61'(a_qc_reg) * 61'(a_lane_reg.tc) + mrope_pkg::Q30_HALF;

    always_comb begin
        b_lane_next    = a_lane_reg;
        b_lane_next.ts = mrope_pkg::Q30_ONE - 31'(step_s >> 30);
        b_lane_next.tc = mrope_pkg::Q30_ONE - 31'(step_c >> 30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_lane_reg <= in_lane;
            a_qs_reg   <= 30'(quo_prod_s >> ShiftS);
            a_qc_reg   <= 30'(quo_prod_c >> ShiftC);
            b_lane_reg <= b_lane_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_lane  = b_lane_reg;

endmodule

@@ rtl/core/mrope_cos_sin_generator.sv @@
// Rotary cos/sin generator. Each accepted s_ beat carries one token's temporal,
// height and width positions; the block then emits min(HEAD_SIZE/2, 64) m_ beats,
// one per frequency slot, carrying the slot index and cos/sin in signed Q1.15,
// with m_tlast on the final slot. A slot sequencer steps through the slots one
// per cycle while the pipeline is not stalled, and the next token is taken in
// the cycle the last slot issues. Each slot runs through a 15-stage pipeline:
// position pick and table lookup, phase multiply, fold, angle, angle squared,
// a row of four Horner cells (two stages each), the final sine multiply and
// the output register. A low m_tready while m_tvalid is high stalls the whole
// pipeline. height_section and width_section are to be written through the
// cfg_ port only while the block is idle; the user must keep to this, as the
// block itself does not enforce it. cfg_index 0 is height_section, 1 is
// width_section.
`include "mrope_cos_sin_generator_defines.svh"

module mrope_cos_sin_generator #(
    parameter int HEAD_SIZE  = 128,
    parameter int THETA_BASE = 5000000,
    parameter int POS_BITS   = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_temporal[19:0], pos_height[39:20], pos_width[59:40]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // freq_index[5:0], cos_value[21:6], sin_value[37:22]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int HalfSlots = HEAD_SIZE / 2;
    localparam int EmitSlots = (HalfSlots > 64) ? 64 : HalfSlots;

    // configuration
    logic [5:0] height_section_reg;
    logic [5:0] width_section_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_section_reg <= mrope_pkg::HEIGHT_SECTION_RST;
            width_section_reg  <= mrope_pkg::WIDTH_SECTION_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                mrope_pkg::REG_HEIGHT_SECTION: height_section_reg <= cfg_data;
                mrope_pkg::REG_WIDTH_SECTION:  width_section_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic m_tvalid_reg;
    logic pipe_en;
    assign pipe_en = !m_tvalid_reg || m_tready;

    // front end and cell row
    logic             chain_valid [mrope_pkg::NUM_CELLS + 1];
    mrope_pkg::lane_t chain_lane  [mrope_pkg::NUM_CELLS + 1];

    mrope_front #(
        .HEAD_SIZE  (HEAD_SIZE),
        .THETA_BASE (THETA_BASE),
        .POS_BITS   (POS_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (pipe_en),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .pos_temporal   (s_tdata[19:0]),
        .pos_height     (s_tdata[39:20]),
        .pos_width      (s_tdata[59:40]),
        .height_section (height_section_reg),
        .width_section  (width_section_reg),
        .lane_valid     (chain_valid[0]),
        .lane           (chain_lane[0])
    );

    for (genvar gc = 0; gc < mrope_pkg::NUM_CELLS; gc++) begin : g_cell
        mrope_cell #(
            .DIV_SIN (mrope_pkg::SIN_DIVS[gc]),
            .DIV_COS (mrope_pkg::COS_DIVS[gc])
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_valid[gc]),
            .in_lane   (chain_lane[gc]),
            .out_valid (chain_valid[gc + 1]),
            .out_lane  (chain_lane[gc + 1])
        );
    end

    // final sine multiply; the last cell already leaves the cosine
    logic             fin_v_reg;
    mrope_pkg::lane_t fin_lane_reg;
    logic [30:0]      fin_sin_reg;
    logic [60:0]      sin_prod;
    mrope_pkg::lane_t tail_lane;

    assign tail_lane = chain_lane[mrope_pkg::NUM_CELLS];
    assign sin_prod  = 61'(tail_lane.x) * 61'(tail_lane.ts) + mrope_pkg::Q30_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (pipe_en) begin
            fin_v_reg <= chain_valid[mrope_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fin_lane_reg <= tail_lane;
            fin_sin_reg  <= 31'(sin_prod >> 30);
        end
    end

    // Q30 to Q1.15 with rounding, clipped at the top
    function automatic logic [15:0] to_q15(logic [30:0] v);
        logic [31:0] r;
        r = ({1'b0, v} + 32'd16384) >> 15;
        if (r > 32'd32767) begin
            return 16'h7FFF;
        end
        return r[15:0];
    endfunction

    logic [15:0] cq;
    logic [15:0] sq;
    logic [15:0] val_a;
    logic [15:0] val_b;
    logic [15:0] cos_next;
    logic [15:0] sin_next;

    assign cq    = to_q15(fin_lane_reg.tc);
    assign sq    = to_q15(fin_sin_reg);
    assign val_a = fin_lane_reg.swap ? sq : cq;
    assign val_b = fin_lane_reg.swap ? cq : sq;

    always_comb begin
        case (fin_lane_reg.quad)
            mrope_pkg::QUAD_I: begin
                cos_next = val_a;
                sin_next = val_b;
            end
            mrope_pkg::QUAD_II: begin
                cos_next = -val_b;
                sin_next = val_a;
            end
            mrope_pkg::QUAD_III: begin
                cos_next = -val_a;
                sin_next = -val_b;
            end
            default: begin
                cos_next = val_b;
                sin_next = -val_a;
            end
        endcase
    end

    // output register
    logic [5:0]  out_idx_reg;
    logic [15:0] out_cos_reg;
    logic [15:0] out_sin_reg;
    logic        out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= fin_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_idx_reg  <= fin_lane_reg.idx;
            out_cos_reg  <= cos_next;
            out_sin_reg  <= sin_next;
            out_last_reg <= fin_lane_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_sin_reg, out_cos_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    `MROPE_ASSERT_NOW(a_last_on_final_slot, aclk, aresetn, m_tvalid,
        m_tlast == (m_tdata[5:0] == 6'(EmitSlots - 1)),
        "last flag out of step with slot index")
    `MROPE_ASSERT_NOW(a_no_negative_full_scale, aclk, aresetn, m_tvalid,
        (m_tdata[21:6] != 16'h8000) && (m_tdata[37:22] != 16'h8000),
        "cos or sin reached -1")
    `MROPE_ASSERT_NEXT(a_stall_holds_final, aclk, aresetn, !pipe_en, $stable(fin_v_reg),
        "final stage moved while stalled")
    `MROPE_ASSERT_NEXT(a_one_token_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "second token taken while slots still issuing")

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAD_SIZE = 128;
    localparam longint unsigned THETA_BASE = 64'd5000000;
    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam bit [63:0] Q30_UNIT = 64'd1 << 30;
    localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam bit [63:0] TURN_PER_RAD_Q32 = 64'd683565276;

    typedef struct packed {
        logic [5:0]         slot;
        logic signed [15:0] cos_q15;
        logic signed [15:0] sin_q15;
        logic               last;
    } slot_result_t;

    typedef struct {
        logic [5:0]  hs;
        logic [5:0]  ws;
        logic [19:0] t;
        logic [19:0] h;
        logic [19:0] w;
        bit          at_rest;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // pos_temporal[19:0], pos_height[39:20], pos_width[59:40]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // freq_index[5:0], cos_value[21:6], sin_value[37:22]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [5:0]  cfg_data;

    mrope_cos_sin_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bit [31:0]    freq_turns [SLOTS];
    logic [5:0]   height_sec;
    logic [5:0]   width_sec;
    slot_result_t pending_slots [$];
    slot_result_t got;
    slot_result_t want;
    int           errors;
    int           cycles;
    int           tx_gap_pct;
    int           rx_stall_pct;

    stim_row_t directed_rows [0:16] = '{
        '{6'd20, 6'd20, 20'h00000, 20'h00000, 20'h00000, 1'b1},
        '{6'd20, 6'd20, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0},
        '{6'd20, 6'd20, 20'h00001, 20'h00002, 20'h00003, 1'b0},
        '{6'd20, 6'd20, 20'hFFFFF, 20'h00000, 20'h00000, 1'b0},
        '{6'd20, 6'd20, 20'h00000, 20'hFFFFF, 20'h00000, 1'b0},
        '{6'd20, 6'd20, 20'h00000, 20'h00000, 20'hFFFFF, 1'b0},
        '{6'd20, 6'd20, 20'h55555, 20'hAAAAA, 20'h12345, 1'b0},
        '{6'd20, 6'd20, 20'hAAAAA, 20'h55555, 20'h80000, 1'b0},
        '{6'd0,  6'd0,  20'd100,   20'd200,   20'd300,   1'b0},
        '{6'd0,  6'd0,  20'h00000, 20'h00000, 20'h00000, 1'b1},
        '{6'd32, 6'd32, 20'd7,     20'd1000,  20'd54321, 1'b0},
        '{6'd32, 6'd0,  20'd9999,  20'd12,    20'hFFFFF, 1'b0},
        '{6'd0,  6'd32, 20'd9999,  20'd12,    20'hFFFFF, 1'b0},
        '{6'd63, 6'd63, 20'h00001, 20'h00002, 20'h00003, 1'b0},
        '{6'd63, 6'd63, 20'hFFFFF, 20'h80000, 20'h7FFFF, 1'b0},
        '{6'd63, 6'd0,  20'd31,    20'd77777, 20'd5,     1'b0},
        '{6'd20, 6'd20, 20'h40000, 20'h3FFFF, 20'h00001, 1'b0}
    };

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit [63:0] q30_mul(bit [63:0] a, bit [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] probe;
        rem = x;
        root = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 64'd0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // theta^(-2i/D) / 2pi per slot, as a 32-bit fraction of a turn
    function automatic void build_freq_turns();
        bit [63:0] mant;
        bit [63:0] frac_bits;
        bit [63:0] log2_theta;
        bit [63:0] expo;
        bit [63:0] whole;
        bit [63:0] v;
        bit [63:0] prod;
        bit [63:0] roots [1:30];
        int msb;
        int s;
        msb = 0;
        while (msb < 63 && (THETA_BASE >> (msb + 1)) != 64'd0) msb++;
        mant = (msb >= 30) ? (THETA_BASE >> (msb - 30)) : (THETA_BASE << (30 - msb));
        frac_bits = 64'd0;
        for (int j = 0; j < 32; j++) begin
            mant = (mant * mant) >> 30;
            frac_bits = frac_bits << 1;
            if (mant >= 2 * Q30_UNIT) begin
                mant = mant >> 1;
                frac_bits = frac_bits | 64'd1;
            end
        end
        log2_theta = (64'(msb) << 32) | frac_bits;
        roots[1] = int_sqrt(64'd1 << 59);
        for (int j = 2; j <= 30; j++) roots[j] = int_sqrt(roots[j - 1] << 30);
        for (int i = 0; i < SLOTS; i++) begin
            expo = log2_theta * 64'(2 * i) / 64'(HEAD_SIZE);
            whole = expo >> 32;
            v = Q30_UNIT;
            for (int j = 1; j <= 30; j++)
                if (expo[32 - j]) v = q30_mul(v, roots[j]);
            if (whole >= 64'd32) begin
                freq_turns[i] = 32'd0;
            end else begin
                s = 30 + int'(whole);
                prod = v * TURN_PER_RAD_Q32;
                freq_turns[i] = 32'((prod + (64'd1 << (s - 1))) >> s);
            end
        end
    endfunction

    function automatic logic signed [15:0] q30_to_q15(bit [63:0] v);
        bit [63:0] r;
        r = (v + (64'd1 << 14)) >> 15;
        return (r > 64'd32767) ? 16'sd32767 : 16'(r);
    endfunction

    function automatic void rotary_cos_sin(input bit [31:0] phase,
                                           output logic signed [15:0] cv,
                                           output logic signed [15:0] sv);
        bit [63:0] r;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] sn;
        bit [63:0] cs;
        bit folded;
        logic signed [15:0] a;
        logic signed [15:0] b;
        r = 64'(phase[29:0]);
        folded = 1'b0;
        // past an eighth of a turn, work from the far end and swap sin/cos
        if (r > (64'd1 << 29)) begin
            r = Q30_UNIT - r;
            folded = 1'b1;
        end
        x = (r * HALF_PI_Q30) >> 30;
        x2 = q30_mul(x, x);
        t = Q30_UNIT - x2 / 72;
        t = Q30_UNIT - q30_mul(x2 / 42, t);
        t = Q30_UNIT - q30_mul(x2 / 20, t);
        t = Q30_UNIT - q30_mul(x2 / 6, t);
        sn = q30_mul(x, t);
        t = Q30_UNIT - x2 / 56;
        t = Q30_UNIT - q30_mul(x2 / 30, t);
        t = Q30_UNIT - q30_mul(x2 / 12, t);
        cs = Q30_UNIT - q30_mul(x2 / 2, t);
        a = folded ? q30_to_q15(sn) : q30_to_q15(cs);
        b = folded ? q30_to_q15(cs) : q30_to_q15(sn);
        case (phase[31:30])
            mrope_pkg::QUAD_I: begin
                cv = a;
                sv = b;
            end
            mrope_pkg::QUAD_II: begin
                cv = -b;
                sv = a;
            end
            mrope_pkg::QUAD_III: begin
                cv = -a;
                sv = -b;
            end
            default: begin
                cv = b;
                sv = -a;
            end
        endcase
    endfunction

    function automatic void predict_token(logic [19:0] t, logic [19:0] h, logic [19:0] w);
        slot_result_t r;
        logic [19:0] pos;
        logic signed [15:0] cv;
        logic signed [15:0] sv;
        for (int i = 0; i < SLOTS; i++) begin
            if (i % 3 == 1 && i < 3 * int'(height_sec)) pos = h;
            else if (i % 3 == 2 && i < 3 * int'(width_sec)) pos = w;
            else pos = t;
            rotary_cos_sin(32'(64'(pos) * 64'(freq_turns[i])), cv, sv);
            r.slot = 6'(i);
            r.cos_q15 = cv;
            r.sin_q15 = sv;
            r.last = (i == SLOTS - 1);
            pending_slots.push_back(r);
        end
    endfunction

    function automatic logic [19:0] pick_pos();
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 255));
            2: begin
                case ($urandom_range(0, 3))
                    0: return 20'h00000;
                    1: return 20'hFFFFF;
                    2: return 20'h80000;
                    default: return 20'h7FFFF;
                endcase
            end
            default: return 20'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [5:0] pick_section();
        // mostly 0 to 32, now and then anywhere from 0 to 63
        if ($urandom_range(0, 5) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 32));
    endfunction

    task automatic send_token(input logic [19:0] t, input logic [19:0] h,
                              input logic [19:0] w, input bit at_rest);
        slot_result_t r;
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {4'd0, w, h, t};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (at_rest) begin
            // zero phase on every slot: full-scale cosine, zero sine
            for (int i = 0; i < SLOTS; i++) begin
                r.slot = 6'(i);
                r.cos_q15 = 16'sd32767;
                r.sin_q15 = 16'sd0;
                r.last = (i == SLOTS - 1);
                pending_slots.push_back(r);
            end
        end else begin
            predict_token(t, h, w);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_slots.size() != 0) @(posedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_sections(input logic [5:0] hs, input logic [5:0] ws);
        cfg_index <= mrope_pkg::REG_HEIGHT_SECTION;
        cfg_data <= hs;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        height_sec = hs;
        @(negedge aclk);
        cfg_index <= mrope_pkg::REG_WIDTH_SECTION;
        cfg_data <= ws;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        width_sec = ws;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d slots outstanding", $time, pending_slots.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.slot = m_tdata[5:0];
            got.cos_q15 = m_tdata[21:6];
            got.sin_q15 = m_tdata[37:22];
            got.last = m_tlast;
            if (pending_slots.size() == 0) begin
                errors++;
                $display("%0t: exp no beat, got slot %0d cos %0d sin %0d last %0b",
                         $time, got.slot, got.cos_q15, got.sin_q15, got.last);
            end else begin
                want = pending_slots.pop_front();
                if (got.slot !== want.slot || got.cos_q15 !== want.cos_q15 ||
                    got.sin_q15 !== want.sin_q15 || got.last !== want.last) begin
                    errors++;
                    $display("%0t: exp slot %0d cos %0d sin %0d last %0b,",
                             $time, want.slot, want.cos_q15, want.sin_q15, want.last);
                    $display("    got slot %0d cos %0d sin %0d last %0b",
                             got.slot, got.cos_q15, got.sin_q15, got.last);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mrope_pkg::REG_HEIGHT_SECTION;
        cfg_data = 6'd0;
        errors = 0;
        cycles = 0;
        tx_gap_pct = 15;
        rx_stall_pct = 53;
        height_sec = mrope_pkg::HEIGHT_SECTION_RST;
        width_sec = mrope_pkg::WIDTH_SECTION_RST;
        build_freq_turns();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].hs != height_sec || directed_rows[n].ws != width_sec) begin
                wait_drained();
                write_sections(directed_rows[n].hs, directed_rows[n].ws);
            end
            send_token(directed_rows[n].t, directed_rows[n].h, directed_rows[n].w,
                       directed_rows[n].at_rest);
        end

        // three pacing modes, two section settings each
        for (int mode = 0; mode < 3; mode++) begin
            tx_gap_pct = (mode == 0) ? 15 : (mode == 1) ? 53 : 0;
            rx_stall_pct = (mode == 0) ? 53 : (mode == 1) ? 15 : 0;
            for (int blk = 0; blk < 2; blk++) begin
                wait_drained();
                write_sections(pick_section(), pick_section());
                for (int k = 0; k < 22; k++) begin
                    // once, in the first mode and block, the sender holds off until the pipe is empty
                    if (mode == 0 && blk == 0 && k == 12) wait_drained();
                    send_token(pick_pos(), pick_pos(), pick_pos(), 1'b0);
                end
            end
        end

        wait_drained();
        repeat (40) @(negedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mrope_pkg.sv
rtl/core/mrope_front.sv
rtl/core/mrope_cell.sv
rtl/core/mrope_cos_sin_generator.sv
bench/tb.sv
